/* rtl/core/tfp_pkg.sv */
// tfp_pkg: shared constants and command/status types for the telemetry frame parser
// used by tfp_ctrl, tfp_dpath, telemetry_frame_parser_crc8, tfp_frame_checker and tb; no dependencies
package tfp_pkg;

   localparam int STORE_DEPTH = 64;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int MAX_LENGTH  = 62;
   localparam int MIN_LENGTH  = 2;
   localparam int IDX_W       = 6;

   localparam logic [7:0] ADDR_SYNC  = 8'hC8;
   localparam logic [7:0] ADDR_RADIO = 8'hEA;
   localparam logic [7:0] CRC_POLY   = 8'hD5;

   // one-cycle strobes from the controller, qualified by an accepted beat, plus the emit_active level
   typedef struct packed {
      logic cap_addr;
      logic cap_len;
      logic cap_type;
      logic put_payload;
      logic start_emit;
      logic emit_active;
   } tfp_cmd_type;

   typedef struct packed {
      logic is_addr;
      logic len_ok;
      logic rem_zero;
      logic rem_one;
      logic crc_match;
      logic emit_done;
   } tfp_status_type;

endpackage

/* rtl/core/telemetry_frame_parser_crc8.sv */
// telemetry_frame_parser_crc8: top level, joins controller and datapath
// depends on tfp_pkg, tfp_ctrl, tfp_dpath
//
//   channel   direction  beat contents                                   handshake
//   req_      in         rx_byte                                         req_valid / req_stall
//   rsp_      out        frame_address, frame_type, data_byte,           rsp_valid / rsp_stall
//                        byte_index, last_byte
//
// one received byte is taken per cycle while parsing
// on a good crc the frame is replayed from the frame store, one beat a cycle while
// rsp_stall is low, and req_stall stays high until all length-1 beats (1 to 61)
// have been read from the store
// rsp_stall holds the result register and pauses the store reads
// reset is synchronous; it clears the phase and the result valid, the store is not cleared
module telemetry_frame_parser_crc8
   import tfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_frame_address,
   output logic [7:0] rsp_frame_type,
   output logic [7:0] rsp_data_byte,
   output logic [5:0] rsp_byte_index,
   output logic       rsp_last_byte
);

   tfp_cmd_type    cmd;
   tfp_status_type status;

   // phase tracking and input back-pressure
   tfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // frame registers, crc, store and result register
   tfp_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_rx_byte       (req_rx_byte),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_address (rsp_frame_address),
      .rsp_frame_type    (rsp_frame_type),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_last_byte     (rsp_last_byte)
   );

   // a good crc beat always opens a replay that holds off the input
   a_emit_stalls: assert property (@(posedge clock) disable iff (reset)
      cmd.start_emit |=> req_stall)
      else $error("replay did not stall input");

   // last store read issued: input opens again next cycle
   a_done_reopens: assert property (@(posedge clock) disable iff (reset)
      status.emit_done |=> !req_stall)
      else $error("input still stalled after replay");

   // a non-final beat leaving means more of the frame is still to be read
   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_byte) |-> req_stall)
      else $error("replay ended before last beat");

   // strobes into the datapath are mutually exclusive
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.cap_addr, cmd.cap_len, cmd.cap_type, cmd.put_payload, cmd.start_emit}))
      else $error("conflicting datapath strobes");

endmodule

/* rtl/core/tfp_ctrl.sv */
// tfp_ctrl: frame phase state machine, drives datapath strobes and req_stall
// depends on tfp_pkg
module tfp_ctrl
   import tfp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  tfp_status_type status,
   output tfp_cmd_type    cmd
);

   localparam logic [2:0] ST_WAIT    = 3'd0;
   localparam logic [2:0] ST_LEN     = 3'd1;
   localparam logic [2:0] ST_TYPE    = 3'd2;
   localparam logic [2:0] ST_PAYLOAD = 3'd3;
   localparam logic [2:0] ST_CRC     = 3'd4;
   localparam logic [2:0] ST_EMIT    = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_stall = (state_ff == ST_EMIT);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.emit_active = (state_ff == ST_EMIT);
      unique case (state_ff)
         ST_LEN: begin
            if (accept) begin
               // bad length: same beat is tried as an address
               priority if (status.len_ok) begin
                  cmd.cap_len = 1'b1;
                  state_in    = ST_TYPE;
               end else if (status.is_addr) begin
                  cmd.cap_addr = 1'b1;
                  state_in     = ST_LEN;
               end else begin
                  state_in = ST_WAIT;
               end
            end
         end
         ST_TYPE: begin
            if (accept) begin
               cmd.cap_type = 1'b1;
               state_in     = status.rem_zero ? ST_CRC : ST_PAYLOAD;
            end
         end
         ST_PAYLOAD: begin
            if (accept) begin
               cmd.put_payload = 1'b1;
               state_in        = status.rem_one ? ST_CRC : ST_PAYLOAD;
            end
         end
         ST_CRC: begin
            if (accept) begin
               cmd.start_emit = status.crc_match;
               state_in       = status.crc_match ? ST_EMIT : ST_WAIT;
            end
         end
         ST_EMIT: begin
            if (status.emit_done) begin
               state_in = ST_WAIT;
            end
         end
         default: begin
            // waiting for an address, unused codes too
            if (accept) begin
               cmd.cap_addr = status.is_addr;
               state_in     = status.is_addr ? ST_LEN : ST_WAIT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/tfp_dpath.sv */
// tfp_dpath: frame registers, running crc, frame store and result register
// depends on tfp_pkg
module tfp_dpath
   import tfp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic [7:0]     req_rx_byte,
   input  tfp_cmd_type    cmd,
   output tfp_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [7:0]     rsp_frame_address,
   output logic [7:0]     rsp_frame_type,
   output logic [7:0]     rsp_data_byte,
   output logic [5:0]     rsp_byte_index,
   output logic           rsp_last_byte
);

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   logic [7:0]       mem [STORE_DEPTH];
   logic [7:0]       addr_ff;
   logic [7:0]       type_ff;
   logic [IDX_W-1:0] length_ff;
   logic [IDX_W-1:0] remain_ff;
   logic [IDX_W-1:0] wpos_ff;
   logic [7:0]       crc_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [IDX_W-1:0] last_idx;
   logic             issue;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wpos;

   logic             out_valid_ff;
   logic [7:0]       out_addr_ff;
   logic [7:0]       out_type_ff;
   logic [7:0]       out_data_ff;
   logic [IDX_W-1:0] out_idx_ff;
   logic             out_last_ff;

   assign last_idx = length_ff - IDX_W'(2);
   assign issue    = cmd.emit_active && (!out_valid_ff || !rsp_stall);
   assign mem_we   = cmd.cap_type || cmd.put_payload;
   assign mem_wpos = cmd.cap_type ? '0 : wpos_ff;

   assign status.is_addr   = (req_rx_byte == ADDR_SYNC) || (req_rx_byte == ADDR_RADIO);
   assign status.len_ok    = (req_rx_byte >= 8'(MIN_LENGTH)) && (req_rx_byte <= 8'(MAX_LENGTH));
   assign status.rem_zero  = (remain_ff == '0);
   assign status.rem_one   = (remain_ff == IDX_W'(1));
   assign status.crc_match = (crc_ff == req_rx_byte);
   assign status.emit_done = issue && (rd_idx_ff == last_idx);

   // frame registers and running crc
   always_ff @(posedge clock) begin
      if (cmd.cap_addr) begin
         addr_ff <= req_rx_byte;
      end
      if (cmd.cap_len) begin
         length_ff <= IDX_W'(req_rx_byte);
         remain_ff <= IDX_W'(req_rx_byte - 8'(MIN_LENGTH));
      end
      if (cmd.cap_type) begin
         type_ff <= req_rx_byte;
         wpos_ff <= IDX_W'(1);
         crc_ff  <= crc8_byte(8'h00, req_rx_byte);
      end
      if (cmd.put_payload) begin
         wpos_ff   <= wpos_ff + IDX_W'(1);
         remain_ff <= remain_ff - IDX_W'(1);
         crc_ff    <= crc8_byte(crc_ff, req_rx_byte);
      end
      if (cmd.start_emit) begin
         rd_idx_ff <= '0;
      end else if (issue) begin
         rd_idx_ff <= rd_idx_ff + IDX_W'(1);
      end
   end

   // frame store, read data lands straight in the result register
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[STORE_AW'(mem_wpos)] <= req_rx_byte;
      end
      if (issue) begin
         out_data_ff <= mem[STORE_AW'(rd_idx_ff)];
         out_addr_ff <= addr_ff;
         out_type_ff <= type_ff;
         out_idx_ff  <= rd_idx_ff;
         out_last_ff <= (rd_idx_ff == last_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (issue) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_frame_address = out_addr_ff;
   assign rsp_frame_type    = out_type_ff;
   assign rsp_data_byte     = out_data_ff;
   assign rsp_byte_index    = out_idx_ff;
   assign rsp_last_byte     = out_last_ff;

endmodule

/* verif/tfp_frame_checker.sv */
// tfp_frame_checker: watches both channels of the telemetry frame parser, predicts
// the replayed frame beats and compares them against the result channel
// depends on tfp_pkg
module tfp_frame_checker
   import tfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_frame_address,
   input  logic [7:0] rsp_frame_type,
   input  logic [7:0] rsp_data_byte,
   input  logic [5:0] rsp_byte_index,
   input  logic       rsp_last_byte,
   output int         mismatches,
   output int         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      AWAIT_ADDR,
      AWAIT_LEN,
      AWAIT_TYPE,
      IN_PAYLOAD,
      AWAIT_CRC
   } parse_state_type;

   typedef struct packed {
      logic [7:0] address;
      logic [7:0] ftype;
      logic [7:0] data;
      logic [5:0] index;
      logic       last;
   } frame_beat_type;

   parse_state_type state;
   logic [7:0]      open_addr;
   logic [7:0]      type_seen;
   logic [7:0]      crc_acc;
   logic [5:0]      frame_len;
   logic [5:0]      left_to_read;
   logic [5:0]      wr_ptr;
   logic [7:0]      body_store [STORE_DEPTH];
   frame_beat_type  beats_due [$];
   frame_beat_type  head;

   // crc-8, msb first, folded in one byte at a time
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

   task automatic take_rx_byte(input logic [7:0] b);
      frame_beat_type fb;
      if (state == AWAIT_LEN) begin
         if (b >= MIN_LENGTH && b <= MAX_LENGTH) begin
            frame_len    = b[5:0];
            left_to_read = b[5:0] - 6'd2;
            state        = AWAIT_TYPE;
            return;
         end
         // bad length: the same byte may open a new frame
         state = AWAIT_ADDR;
      end
      case (state)
         AWAIT_TYPE: begin
            type_seen     = b;
            body_store[0] = b;
            wr_ptr        = 6'd1;
            crc_acc       = crc8_update(8'h00, b);
            if (left_to_read != 6'd0) begin
               state = IN_PAYLOAD;
            end else begin
               state = AWAIT_CRC;
            end
         end
         IN_PAYLOAD: begin
            body_store[wr_ptr] = b;
            wr_ptr       = wr_ptr + 6'd1;
            crc_acc      = crc8_update(crc_acc, b);
            left_to_read = left_to_read - 6'd1;
            if (left_to_read == 6'd0) begin
               state = AWAIT_CRC;
            end
         end
         AWAIT_CRC: begin
            if (crc_acc == b) begin
               for (int i = 0; i < frame_len - 1; i++) begin
                  fb.address = open_addr;
                  fb.ftype   = type_seen;
                  fb.data    = body_store[i];
                  fb.index   = i[5:0];
                  fb.last    = (i == frame_len - 2);
                  beats_due.push_back(fb);
               end
            end
            state = AWAIT_ADDR;
         end
         default: begin
            if (b == ADDR_SYNC || b == ADDR_RADIO) begin
               open_addr = b;
               state     = AWAIT_LEN;
            end else begin
               state = AWAIT_ADDR;
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         state        = AWAIT_ADDR;
         open_addr    = 8'h00;
         type_seen    = 8'h00;
         crc_acc      = 8'h00;
         frame_len    = 6'd0;
         left_to_read = 6'd0;
         wr_ptr       = 6'd0;
         beats_due.delete();
         mismatches   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            take_rx_byte(req_rx_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (beats_due.size() == 0) begin
               mismatches++;
               $display("%0t ns: unexpected beat, expected none, got data %0h index %0d",
                        $time, rsp_data_byte, rsp_byte_index);
            end else begin
               head = beats_due.pop_front();
               check_field("frame_address", head.address, rsp_frame_address);
               check_field("frame_type", head.ftype, rsp_frame_type);
               check_field("data_byte", head.data, rsp_data_byte);
               check_field("byte_index", {2'b00, head.index}, {2'b00, rsp_byte_index});
               check_field("last_byte", {7'd0, head.last}, {7'd0, rsp_last_byte});
            end
         end
      end
      outstanding = beats_due.size();
   end

endmodule

/* verif/tb.sv */
// tb: stimulus and verdict for telemetry_frame_parser_crc8
// depends on tfp_pkg, telemetry_frame_parser_crc8 and tfp_frame_checker
module tb
   import tfp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 170;
   localparam int CYCLE_LIMIT  = 400000;
   // longest replay is 61 beats; leave room for stalls on top
   localparam int DRAIN_CYCLES = 150;
   localparam int LONG_HOLD    = 400;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_stall   = 1'b0;

   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_frame_address;
   logic [7:0] rsp_frame_type;
   logic [7:0] rsp_data_byte;
   logic [5:0] rsp_byte_index;
   logic       rsp_last_byte;

   int mismatches;
   int outstanding;
   int cycle_count   = 0;
   int parsed_items  = 0;

   // calm: sender offers back-to-back beats with no gaps
   bit calm          = 1'b0;
   // one long receiver hold-off, requested by the stimulus, carried out by the receiver
   bit hold_off_req  = 1'b0;
   bit hold_done     = 1'b0;

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   telemetry_frame_parser_crc8 uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_address (rsp_frame_address),
      .rsp_frame_type    (rsp_frame_type),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_last_byte     (rsp_last_byte)
   );

   tfp_frame_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_address (rsp_frame_address),
      .rsp_frame_type    (rsp_frame_type),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_last_byte     (rsp_last_byte),
      .mismatches        (mismatches),
      .outstanding       (outstanding)
   );

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // mostly no gap, some short ones, a few long
   function automatic int random_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // receiver side: random stall runs and free runs, plus the one long hold-off
   initial begin
      int run_left;
      int stall_len;
      run_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req && !hold_done) begin
            // block fills up, replay pauses and req_stall stays high
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(posedge clock);
            hold_done = 1'b1;
            rsp_stall <= 1'b0;
            run_left = 0;
         end else if (run_left > 0) begin
            run_left--;
         end else if (rsp_stall) begin
            rsp_stall <= 1'b0;
            // occasionally a long free stretch with no stall at all
            if ($urandom_range(9) == 0) begin
               run_left = $urandom_range(80, 30);
            end else begin
               run_left = $urandom_range(6);
            end
         end else begin
            stall_len = random_gap();
            if (stall_len > 0) begin
               rsp_stall <= 1'b1;
               run_left = stall_len - 1;
            end
         end
      end
   end

   // one beat on the request channel; called at a rising edge, returns at one
   task automatic send_rx(input logic [7:0] b);
      int gap;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      parsed_items++;
      if (!calm) begin
         gap = random_gap();
         if (gap > 0) begin
            req_valid   <= 1'b0;
            req_rx_byte <= 8'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // whole frame: address, length, type, payload, crc
   // fill below zero gives random body bytes, else every body byte is fill
   task automatic send_frame(input logic [7:0] addr, input int len, input int fill,
                             input bit good_crc);
      logic [7:0] b;
      logic [7:0] crc;
      crc = 8'h00;
      send_rx(addr);
      send_rx(len[7:0]);
      for (int i = 0; i < len - 1; i++) begin
         b = (fill < 0) ? 8'($urandom) : fill[7:0];
         send_rx(b);
         crc = crc ^ b;
         for (int k = 0; k < 8; k++) begin
            crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
         end
      end
      if (!good_crc) begin
         crc = crc ^ 8'($urandom_range(255, 1));
      end
      send_rx(crc);
   endtask

   initial begin
      int         kind;
      int         len;
      int         r;
      int         cut;
      logic [7:0] addr;
      logic [7:0] b;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // noise while waiting for an address is ignored
      send_rx(8'h00);
      send_rx(8'hFF);
      // shortest frame, type only, all-zero body
      send_frame(ADDR_SYNC, MIN_LENGTH, 8'h00, 1'b1);
      // other address, one payload byte, all-ones body
      send_frame(ADDR_RADIO, 3, 8'hFF, 1'b1);
      // lengths out of range on both sides
      send_rx(ADDR_SYNC);
      send_rx(8'd0);
      send_rx(ADDR_RADIO);
      send_rx(8'd1);
      send_rx(ADDR_SYNC);
      send_rx(8'(MAX_LENGTH + 1));
      send_rx(ADDR_RADIO);
      send_rx(8'hFF);
      // address byte in the length slot: rejected, then taken as the new address
      send_rx(ADDR_SYNC);
      send_frame(ADDR_SYNC, MIN_LENGTH, -1, 1'b1);
      // crc mismatch, nothing should come out
      send_frame(ADDR_RADIO, 4, -1, 1'b0);

      // ---- random part ----
      // longest frame first, sent without gaps while the receiver holds off
      calm         = 1'b1;
      hold_off_req = 1'b1;
      send_frame($urandom_range(1) ? ADDR_SYNC : ADDR_RADIO, MAX_LENGTH, -1, 1'b1);

      while (parsed_items < RANDOM_ITEMS) begin
         calm = ($urandom_range(4) == 0);
         kind = $urandom_range(99);
         addr = $urandom_range(1) ? ADDR_SYNC : ADDR_RADIO;
         r    = $urandom_range(99);
         // mostly short frames, some medium, a few of the largest
         if (r < 85) begin
            len = $urandom_range(8, MIN_LENGTH);
         end else if (r < 96) begin
            len = $urandom_range(24, 9);
         end else begin
            len = MAX_LENGTH;
         end
         if (kind < 70) begin
            send_frame(addr, len, -1, 1'b1);
         end else if (kind < 80) begin
            send_frame(addr, len, -1, 1'b0);
         end else if (kind < 88) begin
            // bad length byte
            send_rx(addr);
            if ($urandom_range(1)) begin
               send_rx(8'($urandom_range(MIN_LENGTH - 1)));
            end else begin
               send_rx(8'($urandom_range(255, MAX_LENGTH + 1)));
            end
         end else if (kind < 94) begin
            // frame cut short; the next frame's beats get swallowed as its body
            send_rx(addr);
            send_rx(len[7:0]);
            cut = $urandom_range(len - 1);
            repeat (cut) send_rx(8'($urandom));
         end else begin
            // line noise that never looks like an address
            repeat ($urandom_range(4, 1)) begin
               b = 8'($urandom);
               if (b == ADDR_SYNC || b == ADDR_RADIO) b = b ^ 8'h01;
               send_rx(b);
            end
         end
      end

      // ---- drain ----
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* telemetry_frame_parser_crc8.f */
rtl/core/tfp_pkg.sv
rtl/core/tfp_ctrl.sv
rtl/core/tfp_dpath.sv
rtl/core/telemetry_frame_parser_crc8.sv
verif/tfp_frame_checker.sv
verif/tb.sv
